FILE: rtl/cits_pkg.sv
// cits_pkg: shared widths, codes and types of the cdf inverse-transform sampler
// used by cits_ctrl, cits_dp and cdf_inverse_transform_sampler_unit
// no dependencies
package cits_pkg;

  // table geometry
  localparam int TableDepth = 2048;
  localparam int IdxW       = 11;              // address of one table entry
  localparam int CntW       = 12;              // entry count, holds TableDepth itself
  localparam int WgtW       = 16;
  localparam int SumW       = 27;              // prefix sums of up to TableDepth weights
  localparam int UniW       = 24;
  localparam int FrcW       = 16;
  localparam int ValW       = 24;
  localparam int TgtW       = SumW + UniW;     // u * total and prefix << UniW
  localparam int PosW       = IdxW + FrcW + 1;
  localparam int ProdW      = TgtW + 1;
  localparam int StepW      = 5;
  localparam int FracSteps  = FrcW;
  localparam int DivSteps   = ValW;
  localparam int AddrW      = 3;
  localparam int DataW      = 32;

  // result status codes
  typedef enum logic [2:0] {
    ST_WEIGHT    = 3'd0,
    ST_READY     = 3'd1,
    ST_ZERO      = 3'd2,
    ST_SAMPLE    = 3'd3,
    ST_NOT_READY = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_e;

  // request type codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // register index of max_value
  localparam logic REG_MAX_VALUE = 1'b0;

  typedef struct packed {
    logic              req_type;
    logic [WgtW-1:0]   weight;
    logic              last;
    logic [UniW-1:0]   uniform;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ValW-1:0]   sample_value;
    logic [IdxW-1:0]   bin_index;
    logic [FrcW-1:0]   bin_fraction;
  } res_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic reject;
    logic begin_smp;
    logic mul;
    logic srch_rd;
    logic srch_cmp;
    logic rd_cur;
    logic rd_prev;
    logic frac_set;
    logic frac_chk;
    logic frac_step;
    logic scale;
    logic div_step;
    logic emit;
    logic emit_zero;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic ready;
    logic srch_done;
    logic idx_zero;
    logic frac_skip;
  } dp_stat_t;

endpackage

FILE: rtl/cdf_inverse_transform_sampler_unit.sv
// cdf_inverse_transform_sampler_unit: top level, configuration port and assertions
// depends on cits_pkg, cits_ctrl and cits_dp
//
// A load (req_type 0) is taken and its result beat follows in the next cycle; busy
// stays low, so loads may be issued every cycle. A sample request on a ready table
// keeps busy high through a binary search of s steps, s at most ceil(log2(count+1))
// and so at most 12; each step takes a read state and a compare state for the
// single registered read port of the prefix store, followed by a 16-step fraction
// divider (skipped when the fraction is settled without division) and a 24-step
// quotient divider; bin zero is emitted straight after the search. A sample on a
// table that is not ready returns in the next cycle. Result beats are shown for one
// cycle on res_valid_o and cannot be held off. max_value is register 0 at byte address
// 0; the user must write it only while busy is low, as the block does not enforce it.
module cdf_inverse_transform_sampler_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  cits_pkg::req_t                req_i,
  output logic                          res_valid_o,
  output cits_pkg::res_t                res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cits_pkg::AddrW-1:0]    paddr,
  input  logic [cits_pkg::DataW-1:0]    pwdata,
  output logic [cits_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  logic [cits_pkg::ValW-1:0] max_value_q;
  cits_pkg::cmd_t            cmd;
  cits_pkg::dp_stat_t        stat;
  logic                      accept;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= {cits_pkg::ValW{1'b1}};
    end else if (psel && penable && pwrite && (paddr[2] == cits_pkg::REG_MAX_VALUE)) begin
      max_value_q <= pwdata[cits_pkg::ValW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == cits_pkg::REG_MAX_VALUE)
                  ? cits_pkg::DataW'(max_value_q) : '0;

  assign accept = start_i && !busy_o;

  cits_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .req_type_i (req_i.req_type),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  cits_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .max_value_i (max_value_q),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // a load always answers in the next cycle
  a_load_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.req_type == cits_pkg::REQ_LOAD) |=> res_valid_o)
    else $error("load without result beat");

  // no result beat while a sample is in progress
  a_quiet_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !res_valid_o)
    else $error("result beat while busy");

  // only sample results carry payload
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status != cits_pkg::ST_SAMPLE) |->
      (res_o.sample_value == '0) && (res_o.bin_index == '0) && (res_o.bin_fraction == '0))
    else $error("payload on non-sample result");

endmodule

FILE: rtl/cits_dp.sv
// cits_dp: prefix-sum store, search registers, bit-serial dividers and result register
// depends on cits_pkg; driven by commands from cits_ctrl
module cits_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cits_pkg::cmd_t                 cmd_i,
  input  cits_pkg::req_t                 req_i,
  input  logic [cits_pkg::ValW-1:0]      max_value_i,
  output cits_pkg::dp_stat_t             stat_o,
  output logic                           res_valid_o,
  output cits_pkg::res_t                 res_o
);

  // prefix store, reset value undefined
  logic [cits_pkg::SumW-1:0] store_q [cits_pkg::TableDepth];
  logic [cits_pkg::SumW-1:0] rdata_q;
  logic                      we;
  logic [cits_pkg::IdxW-1:0] waddr, raddr;
  logic [cits_pkg::SumW-1:0] wdata;

  // table state
  logic [cits_pkg::CntW-1:0] count_q, count_d;
  logic [cits_pkg::SumW-1:0] total_q, total_d;
  logic                      ready_q, ready_d;

  // sample working registers
  logic [cits_pkg::UniW-1:0]  u_q;
  logic [cits_pkg::TgtW-1:0]  target_q;
  logic [cits_pkg::CntW-1:0]  lo_q, hi_q;
  logic [cits_pkg::IdxW-1:0]  mid_q, idx_q;
  logic [cits_pkg::SumW-1:0]  cur_q;
  logic [cits_pkg::TgtW-1:0]  rem_q, den_q;
  logic                       zw_q, ge_q;
  logic [cits_pkg::FrcW:0]    f_q;
  logic [cits_pkg::ProdW-1:0] prod_q, dsh_q;
  logic [cits_pkg::ValW-1:0]  quot_q;

  logic                       res_valid_q, res_valid_d;
  cits_pkg::res_t             res_q, res_d;

  // combinational helpers
  logic [cits_pkg::CntW-1:0]  c_eff;
  logic [cits_pkg::SumW-1:0]  t_eff, t_new;
  logic [cits_pkg::CntW:0]    mid_sum;
  logic [cits_pkg::IdxW-1:0]  mid, idx, idx_m1;
  logic [cits_pkg::CntW-1:0]  cnt_m1;
  logic [cits_pkg::TgtW-1:0]  base, probe;
  logic [cits_pkg::TgtW:0]    remsh;
  logic [cits_pkg::SumW-1:0]  width;
  logic [cits_pkg::PosW-1:0]  pos;

  always_comb begin
    c_eff   = ready_q ? '0 : count_q;
    t_eff   = ready_q ? '0 : total_q;
    t_new   = t_eff + cits_pkg::SumW'(req_i.weight);
    mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
    mid     = mid_sum[cits_pkg::IdxW:1];
    cnt_m1  = count_q - cits_pkg::CntW'(1);
    idx     = (lo_q != count_q) ? lo_q[cits_pkg::IdxW-1:0] : cnt_m1[cits_pkg::IdxW-1:0];
    idx_m1  = idx_q - cits_pkg::IdxW'(1);
    probe   = {rdata_q, {cits_pkg::UniW{1'b0}}};
    base    = {rdata_q, {cits_pkg::UniW{1'b0}}};
    width   = cur_q - rdata_q;
    remsh   = {rem_q, 1'b0};
    pos     = {1'b0, idx_m1, {cits_pkg::FrcW{1'b0}}} + cits_pkg::PosW'(f_q);
  end

  assign stat_o.ready     = ready_q;
  assign stat_o.srch_done = !(lo_q < hi_q);
  assign stat_o.idx_zero  = (idx == '0);
  assign stat_o.frac_skip = zw_q || !ge_q || (rem_q >= den_q);

  // memory write and read ports
  always_comb begin
    we    = cmd_i.load && (c_eff < cits_pkg::CntW'(cits_pkg::TableDepth));
    waddr = c_eff[cits_pkg::IdxW-1:0];
    wdata = t_new;
    raddr = mid;
    if (cmd_i.rd_cur) begin
      raddr = idx;
    end else if (cmd_i.rd_prev) begin
      raddr = idx_m1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[waddr] <= wdata;
    end
    rdata_q <= store_q[raddr];
  end

  // table state and result beat
  always_comb begin
    count_d     = count_q;
    total_d     = total_q;
    ready_d     = ready_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    if (cmd_i.load) begin
      res_valid_d = 1'b1;
      if (c_eff >= cits_pkg::CntW'(cits_pkg::TableDepth)) begin
        count_d       = '0;
        total_d       = '0;
        ready_d       = 1'b0;
        res_d.status  = cits_pkg::ST_OVERFLOW;
      end else if (req_i.last && (t_new == '0)) begin
        count_d       = '0;
        total_d       = '0;
        ready_d       = 1'b0;
        res_d.status  = cits_pkg::ST_ZERO;
      end else begin
        count_d       = c_eff + cits_pkg::CntW'(1);
        total_d       = t_new;
        ready_d       = req_i.last;
        res_d.status  = req_i.last ? cits_pkg::ST_READY : cits_pkg::ST_WEIGHT;
      end
    end else if (cmd_i.reject) begin
      res_valid_d  = 1'b1;
      res_d.status = cits_pkg::ST_NOT_READY;
    end else if (cmd_i.emit_zero) begin
      res_valid_d  = 1'b1;
      res_d.status = cits_pkg::ST_SAMPLE;
    end else if (cmd_i.emit) begin
      res_valid_d        = 1'b1;
      res_d.status       = cits_pkg::ST_SAMPLE;
      res_d.sample_value = quot_q;
      res_d.bin_index    = idx_m1;
      res_d.bin_fraction = f_q[cits_pkg::FrcW] ? {cits_pkg::FrcW{1'b1}}
                                               : f_q[cits_pkg::FrcW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      total_q     <= '0;
      ready_q     <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      count_q     <= count_d;
      total_q     <= total_d;
      ready_q     <= ready_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  // sample working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.begin_smp) begin
      u_q <= req_i.uniform;
    end
    // normalisation target and search bounds
    if (cmd_i.mul) begin
      target_q <= cits_pkg::TgtW'(u_q) * cits_pkg::TgtW'(total_q);
      lo_q     <= '0;
      hi_q     <= count_q;
    end
    if (cmd_i.srch_rd) begin
      mid_q <= mid;
    end
    if (cmd_i.srch_cmp) begin
      if (probe >= target_q) begin
        hi_q <= {1'b0, mid_q};
      end else begin
        lo_q <= {1'b0, mid_q} + cits_pkg::CntW'(1);
      end
    end
    if (cmd_i.rd_cur) begin
      idx_q <= idx;
    end
    if (cmd_i.rd_prev) begin
      cur_q <= rdata_q;
    end
    // bin width and remainder above lower edge
    if (cmd_i.frac_set) begin
      den_q <= {width, {cits_pkg::UniW{1'b0}}};
      rem_q <= target_q - base;
      ge_q  <= (target_q >= base);
      zw_q  <= (width == '0);
    end
    if (cmd_i.frac_chk) begin
      if (zw_q || !ge_q) begin
        f_q <= '0;
      end else if (rem_q >= den_q) begin
        f_q <= {1'b1, {cits_pkg::FrcW{1'b0}}};
      end else begin
        f_q <= '0;
      end
    end
    // one fraction bit per beat
    if (cmd_i.frac_step) begin
      if (remsh >= {1'b0, den_q}) begin
        rem_q <= cits_pkg::TgtW'(remsh - {1'b0, den_q});
        f_q   <= {f_q[cits_pkg::FrcW-1:0], 1'b1};
      end else begin
        rem_q <= remsh[cits_pkg::TgtW-1:0];
        f_q   <= {f_q[cits_pkg::FrcW-1:0], 1'b0};
      end
    end
    // scale by max_value, divisor aligned to top quotient bit
    if (cmd_i.scale) begin
      prod_q <= cits_pkg::ProdW'(max_value_i) * cits_pkg::ProdW'(pos);
      dsh_q  <= {2'b00, cnt_m1[cits_pkg::IdxW-1:0], {cits_pkg::FrcW{1'b0}},
                 {(cits_pkg::ValW-1){1'b0}}};
      quot_q <= '0;
    end
    // one quotient bit per beat
    if (cmd_i.div_step) begin
      if (prod_q >= dsh_q) begin
        prod_q <= prod_q - dsh_q;
        quot_q <= {quot_q[cits_pkg::ValW-2:0], 1'b1};
      end else begin
        quot_q <= {quot_q[cits_pkg::ValW-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/cits_ctrl.sv
// cits_ctrl: sequencing state machine of the sampler
// depends on cits_pkg; drives cits_dp through cmd_t, reads dp_stat_t
module cits_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 req_type_i,
  input  cits_pkg::dp_stat_t   stat_i,
  output cits_pkg::cmd_t       cmd_o,
  output logic                 busy_o
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_MUL      = 11'b00000000010,
    S_SRCH_RD  = 11'b00000000100,
    S_SRCH_CMP = 11'b00000001000,
    S_RD_CUR   = 11'b00000010000,
    S_RD_PREV  = 11'b00000100000,
    S_FRAC_SET = 11'b00001000000,
    S_FRAC_CHK = 11'b00010000000,
    S_FRAC     = 11'b00100000000,
    S_SCALE    = 11'b01000000000,
    S_DIV      = 11'b10000000000
  } state_e;

  state_e                     state_q, state_d;
  logic [cits_pkg::StepW-1:0] step_q, step_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (req_type_i == cits_pkg::REQ_LOAD) begin
            cmd_o.load = 1'b1;
          end else if (!stat_i.ready) begin
            cmd_o.reject = 1'b1;
          end else begin
            cmd_o.begin_smp = 1'b1;
            state_d         = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SRCH_RD;
      end
      S_SRCH_RD: begin
        if (stat_i.srch_done) begin
          state_d = S_RD_CUR;
        end else begin
          cmd_o.srch_rd = 1'b1;
          state_d       = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        cmd_o.srch_cmp = 1'b1;
        state_d        = S_SRCH_RD;
      end
      S_RD_CUR: begin
        if (stat_i.idx_zero) begin
          cmd_o.emit_zero = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.rd_cur = 1'b1;
          state_d      = S_RD_PREV;
        end
      end
      S_RD_PREV: begin
        cmd_o.rd_prev = 1'b1;
        state_d       = S_FRAC_SET;
      end
      S_FRAC_SET: begin
        cmd_o.frac_set = 1'b1;
        state_d        = S_FRAC_CHK;
      end
      S_FRAC_CHK: begin
        cmd_o.frac_chk = 1'b1;
        step_d         = '0;
        state_d        = stat_i.frac_skip ? S_SCALE : S_FRAC;
      end
      S_FRAC: begin
        cmd_o.frac_step = 1'b1;
        step_d          = step_q + cits_pkg::StepW'(1);
        if (step_q == cits_pkg::StepW'(cits_pkg::FracSteps - 1)) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        step_d      = '0;
        state_d     = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + cits_pkg::StepW'(1);
        if (step_q == cits_pkg::StepW'(cits_pkg::DivSteps - 1)) begin
          cmd_o.div_step = 1'b0;
          cmd_o.emit     = 1'b0;
        end
        if (step_q == cits_pkg::StepW'(cits_pkg::DivSteps)) begin
          cmd_o.div_step = 1'b0;
          cmd_o.emit     = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
